### hdl/rwsp_pkg.sv
// Package: shared types, stream markers and the word analysis function of the hit parser.
`default_nettype none
package rwsp_pkg;

    // Stream markers
    localparam logic [31:0] MARK_END        = 32'hfafafafa;
    localparam logic [23:0] MARK_EVT_HEADER = 24'h564d32;
    localparam logic [31:0] MARK_EVT_EMPTY  = 32'h00564132;
    localparam logic [31:0] MARK_EQ_HEADER  = 32'hda1e5afe;
    localparam logic [31:0] MARK_EQ_START   = 32'h00000050;

    // Equipment header positions and checks
    localparam logic [4:0]  HDR_CNT_MAX     = 5'd31;
    localparam logic [4:0]  HDR_CHECK_POS   = 5'd3;
    localparam logic [31:0] HDR_CHECK_VALUE = 32'd7;
    localparam logic [4:0]  HDR_FE_POS      = 5'd22;

    // Event word positions
    localparam logic [1:0]  EVT_POS_CHIP    = 2'd1;
    localparam logic [1:0]  EVT_POS_TRIG    = 2'd2;
    localparam logic [1:0]  EVT_POS_DATA    = 2'd3;

    // Parser state apart from the word history and the wrap counter
    typedef struct packed {
        logic        in_event;
        logic        in_equip;
        logic [4:0]  hdr_cnt;
        logic [1:0]  evt_pos;
        logic        evt_par;
        logic [7:0]  frontend;
        logic [7:0]  chip;
        logic [31:0] trig;
    } t_state;

    // Outcome of analysing one word
    typedef struct packed {
        t_state st;
        logic   hit;
        logic   wrap_inc;
    } t_step;

    // Context of a step handed from the tracker to the hit decoder
    typedef struct packed {
        logic        hit;
        logic [7:0]  frontend_id;
        logic [7:0]  chip_id;
        logic [31:0] trigger_time;
        logic [31:0] trigger_wraps;
        logic [31:0] hit_word;
        logic [31:0] time_word;
    } t_hit_ctx;

    // One result item
    typedef struct packed {
        logic [7:0]  frontend_id;
        logic [7:0]  chip_id;
        logic [5:0]  channel;
        logic        hit_flag;
        logic        above_thr;
        logic [9:0]  amplitude;
        logic [11:0] bunch_id;
        logic [7:0]  fine_time;
        logic [31:0] trigger_time;
        logic [31:0] trigger_wraps;
    } t_hit;

    // Analyse word w with previous words p and pp
    function automatic t_step analyse(input t_state s, input logic [31:0] w,
                                      input logic [31:0] p, input logic [31:0] pp);
        t_step r;
        r.st       = s;
        r.hit      = 1'b0;
        r.wrap_inc = 1'b0;

        // headers and markers seen in the previous word
        if (p[31:8] == MARK_EVT_HEADER) begin
            r.st.in_event = 1'b1;
            r.st.in_equip = 1'b0;
            r.st.hdr_cnt  = '0;
            r.st.evt_pos  = '0;
            r.st.evt_par  = 1'b0;
        end else if (p == MARK_EVT_EMPTY) begin
            r.st.in_event = 1'b0;
        end else if (p == MARK_EQ_HEADER && w == MARK_EQ_START) begin
            r.st.in_event = 1'b0;
            if (pp != MARK_EQ_START) begin
                r.st.in_equip = 1'b1;
            end
        end

        // equipment header tracking
        if (r.st.in_equip) begin
            if (r.st.hdr_cnt != HDR_CNT_MAX) begin
                r.st.hdr_cnt = r.st.hdr_cnt + 5'd1;
            end
            if (r.st.hdr_cnt == HDR_CHECK_POS && w != HDR_CHECK_VALUE) begin
                r.st.in_equip = 1'b0;
            end
            if (r.st.hdr_cnt == HDR_FE_POS) begin
                r.st.frontend = p[7:0];
            end
        end

        // event body: chip id, trigger time, then word pairs
        if (r.st.in_event) begin
            if (r.st.evt_pos != EVT_POS_DATA) begin
                r.st.evt_pos = r.st.evt_pos + 2'd1;
            end
            r.st.evt_par = ~r.st.evt_par;
            if (r.st.evt_pos == EVT_POS_CHIP) begin
                r.st.chip = p[7:0];
            end else if (w[31:8] != MARK_EVT_HEADER && w != MARK_END) begin
                if (r.st.evt_pos == EVT_POS_TRIG) begin
                    r.wrap_inc = (r.st.trig > p);
                    r.st.trig  = p;
                end
                if (r.st.evt_pos == EVT_POS_DATA && !r.st.evt_par) begin
                    r.hit = 1'b1;
                end
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### hdl/rwsp_word_if.sv
// Interface: input channel carrying one raw readout word per request.
`default_nettype none
interface rwsp_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface
`default_nettype wire

### hdl/rwsp_hit_if.sv
// Interface: output channel carrying one decoded hit per request.
`default_nettype none
interface rwsp_hit_if;
    logic        valid;
    logic        ready;
    logic [7:0]  frontend_id;
    logic [7:0]  chip_id;
    logic [5:0]  channel;
    logic        hit_flag;
    logic        above_thr;
    logic [9:0]  amplitude;
    logic [11:0] bunch_id;
    logic [7:0]  fine_time;
    logic [31:0] trigger_time;
    logic [31:0] trigger_wraps;

    modport source (output valid, output frontend_id, output chip_id, output channel,
                    output hit_flag, output above_thr, output amplitude,
                    output bunch_id, output fine_time, output trigger_time,
                    output trigger_wraps, input ready);
    modport sink   (input valid, input frontend_id, input chip_id, input channel,
                    input hit_flag, input above_thr, input amplitude,
                    input bunch_id, input fine_time, input trigger_time,
                    input trigger_wraps, output ready);
endinterface
`default_nettype wire

### hdl/readout_word_stream_hit_parser_top.sv
// Top level: input register, tracker, hit decoder and result register.
//
//  Channel   Dir  Modport  Payload
//  i_word    in   sink     word[31:0] raw readout word
//  o_hit     out  source   frontend_id, chip_id, channel, hit_flag, above_thr,
//                          amplitude, bunch_id, fine_time, trigger_time, trigger_wraps
//
// One word per cycle sustained while o_hit keeps up; an accepted word is held in the
// input register and processed from there, and a hit is shown from the result register.
// Reset (synchronous, active low) clears the word history, all tracking state,
// the wrap counter and both valid flags.
// Every word, hit or not, needs a free or draining result register to advance;
// while a hit waits on o_hit one word sits in the input register and ready drops.
`default_nettype none
module readout_word_stream_hit_parser_top #(
    parameter int WRAP_WIDTH = 32
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    rwsp_word_if.sink    i_word,
    rwsp_hit_if.source   o_hit
);

    logic               r_in_valid;
    logic [31:0]        r_in_word;
    logic               r_out_valid;
    rwsp_pkg::t_hit     r_hit;

    logic               n_in_valid;
    logic               n_out_valid;

    logic               w_step;
    logic               w_accept;
    rwsp_pkg::t_hit_ctx w_ctx;
    rwsp_pkg::t_hit     w_hit;

    // Handshake: the held word is processed whenever the result register can take it
    assign w_step       = r_in_valid && (!r_out_valid || o_hit.ready);
    assign i_word.ready = !r_in_valid || w_step;
    assign w_accept     = i_word.valid && i_word.ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (w_step) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_step && w_ctx.hit) begin
            n_out_valid = 1'b1;
        end else if (o_hit.ready) begin
            n_out_valid = 1'b0;
        end
    end

    rwsp_tracker #(
        .WRAP_WIDTH (WRAP_WIDTH)
    ) u_tracker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_word  (r_in_word),
        .o_ctx   (w_ctx)
    );

    rwsp_hit_decode u_decode (
        .i_ctx (w_ctx),
        .o_hit (w_hit)
    );

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_word <= i_word.word;
        end
        if (w_step && w_ctx.hit) begin
            r_hit <= w_hit;
        end
    end

    // Result port
    assign o_hit.valid          = r_out_valid;
    assign o_hit.frontend_id    = r_hit.frontend_id;
    assign o_hit.chip_id        = r_hit.chip_id;
    assign o_hit.channel        = r_hit.channel;
    assign o_hit.hit_flag       = r_hit.hit_flag;
    assign o_hit.above_thr      = r_hit.above_thr;
    assign o_hit.amplitude      = r_hit.amplitude;
    assign o_hit.bunch_id       = r_hit.bunch_id;
    assign o_hit.fine_time      = r_hit.fine_time;
    assign o_hit.trigger_time   = r_hit.trigger_time;
    assign o_hit.trigger_wraps  = r_hit.trigger_wraps;

endmodule
`default_nettype wire

### hdl/rwsp_tracker.sv
// Tracker: word history, header and event state, trigger wrap counter.
`default_nettype none
module rwsp_tracker #(
    parameter int WRAP_WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire logic [31:0]        i_word,
    output rwsp_pkg::t_hit_ctx      o_ctx
);

    logic [31:0]           r_prev;
    logic [31:0]           r_prev2;
    rwsp_pkg::t_state      r_st;
    logic [WRAP_WIDTH-1:0] r_wrap;

    logic [31:0]           n_prev2;
    rwsp_pkg::t_state      n_st;
    logic [WRAP_WIDTH-1:0] n_wrap;

    rwsp_pkg::t_state      w_end_st;
    rwsp_pkg::t_step       w_phantom;
    rwsp_pkg::t_step       w_after_end;
    rwsp_pkg::t_step       w_normal;
    rwsp_pkg::t_step       w_res;
    logic                  w_end;
    logic [31:0]           w_wraps;

    // End marker: close the event, analyse a zero word, then the current word with no history
    always_comb begin
        w_end_st          = r_st;
        w_end_st.in_event = 1'b0;
        w_phantom   = rwsp_pkg::analyse(w_end_st, '0, '0, '0);
        w_after_end = rwsp_pkg::analyse(w_phantom.st, i_word, '0, '0);
        w_normal    = rwsp_pkg::analyse(r_st, i_word, r_prev, r_prev2);
        w_end       = (r_prev == rwsp_pkg::MARK_END);
        w_res       = w_end ? w_after_end : w_normal;
        n_st        = w_res.st;
        n_prev2     = w_end ? '0 : r_prev;
        n_wrap      = r_wrap + {{(WRAP_WIDTH-1){1'b0}}, w_res.wrap_inc};
    end

    // Low 32 bits of the wrap counter
    generate
        if (WRAP_WIDTH >= 32) begin : g_wide
            assign w_wraps = n_wrap[31:0];
        end else begin : g_narrow
            assign w_wraps = {{(32-WRAP_WIDTH){1'b0}}, n_wrap};
        end
    endgenerate

    // Context of this step, with the ids and trigger after the update
    always_comb begin
        o_ctx.hit           = w_res.hit;
        o_ctx.frontend_id   = n_st.frontend;
        o_ctx.chip_id       = n_st.chip;
        o_ctx.trigger_time  = n_st.trig;
        o_ctx.trigger_wraps = w_wraps;
        o_ctx.hit_word      = r_prev;
        o_ctx.time_word     = r_prev2;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_prev2 <= '0;
            r_st    <= '0;
            r_wrap  <= '0;
        end else if (i_step) begin
            r_prev  <= i_word;
            r_prev2 <= n_prev2;
            r_st    <= n_st;
            r_wrap  <= n_wrap;
        end
    end

endmodule
`default_nettype wire

### hdl/rwsp_hit_decode.sv
// Hit decoder: bit reversal of the word pair, field extraction and Gray decode.
`default_nettype none
module rwsp_hit_decode (
    input  wire rwsp_pkg::t_hit_ctx i_ctx,
    output rwsp_pkg::t_hit          o_hit
);

    logic [31:0] w_s;
    logic [31:0] w_t;
    logic [11:0] w_gray;
    logic [11:0] w_g8;
    logic [11:0] w_g4;
    logic [11:0] w_g2;
    logic [11:0] w_bin;

    // Bit-reverse both words of the pair
    always_comb begin
        for (int i = 0; i < 32; i++) begin
            w_s[i] = i_ctx.hit_word[31-i];
            w_t[i] = i_ctx.time_word[31-i];
        end
    end

    // Gray to binary as a prefix XOR
    always_comb begin
        w_gray = {w_t[5:0], w_t[15:10]};
        w_g8   = w_gray ^ (w_gray >> 8);
        w_g4   = w_g8 ^ (w_g8 >> 4);
        w_g2   = w_g4 ^ (w_g4 >> 2);
        w_bin  = w_g2 ^ (w_g2 >> 1);
    end

    // Result fields
    always_comb begin
        o_hit.frontend_id    = i_ctx.frontend_id;
        o_hit.chip_id        = i_ctx.chip_id;
        o_hit.channel        = w_s[7:2];
        o_hit.hit_flag       = w_s[0];
        o_hit.above_thr      = w_s[1];
        o_hit.amplitude      = {w_t[17:16], w_t[31:24]};
        o_hit.bunch_id       = w_bin;
        o_hit.fine_time      = {w_t[9:8], w_t[23:18]};
        o_hit.trigger_time   = i_ctx.trigger_time;
        o_hit.trigger_wraps  = i_ctx.trigger_wraps;
    end

endmodule
`default_nettype wire

### hdl/rwsp_checker.sv
// Checker: port-level assertions of the hit parser, bound to the top level.
`default_nettype none
module rwsp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_word_valid,
    input wire logic        i_word_ready,
    input wire logic        o_hit_valid,
    input wire logic        o_hit_ready,
    input wire logic [31:0] o_hit_trigger_time,
    input wire logic [31:0] o_hit_trigger_wraps
);

    // No result right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_hit_valid)
        else $error("result valid after reset");

    // With the result register empty, the input side always takes a word
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_hit_valid |-> i_word_ready)
        else $error("input stalled with no pending result");

    // Hits come from word pairs, so a delivered result is never followed at once by another
    a_no_adjacent_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_hit_valid && o_hit_ready) |=> !o_hit_valid)
        else $error("results in adjacent cycles");

    // A stalled result keeps its timing fields
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_hit_valid && !o_hit_ready) |=>
            (o_hit_valid && $stable(o_hit_trigger_time) && $stable(o_hit_trigger_wraps)))
        else $error("stalled result changed");

endmodule

bind readout_word_stream_hit_parser_top rwsp_checker u_rwsp_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_word_valid        (i_word.valid),
    .i_word_ready        (i_word.ready),
    .o_hit_valid         (o_hit.valid),
    .o_hit_ready         (o_hit.ready),
    .o_hit_trigger_time  (o_hit.trigger_time),
    .o_hit_trigger_wraps (o_hit.trigger_wraps)
);
`default_nettype wire

### test/tb.sv
// Testbench for the readout word hit parser: directed table, random streams, self-checking.
`timescale 1ns / 100ps
module tb;

    localparam int ITEM_TARGET    = 1050;
    localparam int PRESSURE_AT    = 400;
    localparam int PRESSURE_WORDS = 60;
    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_CYCLES    = 8;
    localparam int RUN_LIMIT_NS   = 4_000_000;

    typedef enum logic {ROW_PREDICTED, ROW_TYPED} t_row_kind;

    typedef struct packed {
        logic [31:0]    word;
        t_row_kind      kind;
        rwsp_pkg::t_hit hit;
    } t_dir_row;

    localparam rwsp_pkg::t_hit NO_HIT = '0;
    // pair of zero words in the first event
    localparam rwsp_pkg::t_hit HIT_ZEROS = '{8'h00, 8'hab, 6'd0, 1'b0, 1'b0, 10'd0, 12'd0,
                                             8'd0, 32'h0000_0100, 32'd0};
    // pair of all-ones words in the first event
    localparam rwsp_pkg::t_hit HIT_ONES  = '{8'h00, 8'hab, 6'd63, 1'b1, 1'b1, 10'd1023,
                                             12'haaa, 8'hff, 32'h0000_0100, 32'd0};
    // first pair after a trigger time that went down
    localparam rwsp_pkg::t_hit HIT_WRAP  = '{8'h00, 8'h00, 6'd0, 1'b0, 1'b0, 10'd0, 12'd0,
                                             8'd0, 32'h0000_0010, 32'd1};

    localparam int DIR_ROWS = 27;
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{32'hffff_ffff,                      ROW_PREDICTED, NO_HIT},
        '{{rwsp_pkg::MARK_EVT_HEADER, 8'hab}, ROW_PREDICTED, NO_HIT},  // event opens, chip ab
        '{32'h0000_0100,                      ROW_PREDICTED, NO_HIT},  // trigger time
        '{32'h0000_0000,                      ROW_PREDICTED, NO_HIT},
        '{32'h0000_0000,                      ROW_PREDICTED, NO_HIT},
        '{32'hffff_ffff,                      ROW_TYPED,     HIT_ZEROS},
        '{32'hffff_ffff,                      ROW_PREDICTED, NO_HIT},
        '{32'h0000_0000,                      ROW_TYPED,     HIT_ONES},
        '{32'h5a5a_1234,                      ROW_PREDICTED, NO_HIT},
        '{{rwsp_pkg::MARK_EVT_HEADER, 8'h00}, ROW_PREDICTED, NO_HIT},  // header closes a pair
        '{32'h0000_0010,                      ROW_PREDICTED, NO_HIT},  // lower trigger time
        '{32'h0000_0000,                      ROW_PREDICTED, NO_HIT},
        '{32'h0000_0000,                      ROW_PREDICTED, NO_HIT},
        '{32'h0000_0000,                      ROW_TYPED,     HIT_WRAP},
        '{32'h0000_0000,                      ROW_PREDICTED, NO_HIT},
        '{rwsp_pkg::MARK_END,                 ROW_PREDICTED, NO_HIT},  // end marker in a pair
        '{32'h1234_5678,                      ROW_PREDICTED, NO_HIT},  // history cleared
        '{{rwsp_pkg::MARK_EVT_HEADER, 8'h77}, ROW_PREDICTED, NO_HIT},
        '{32'h0000_0020,                      ROW_PREDICTED, NO_HIT},
        '{rwsp_pkg::MARK_EQ_START,            ROW_PREDICTED, NO_HIT},
        '{rwsp_pkg::MARK_EQ_HEADER,           ROW_PREDICTED, NO_HIT},
        '{rwsp_pkg::MARK_EQ_START,            ROW_PREDICTED, NO_HIT},  // repeated start closes
        '{rwsp_pkg::MARK_EVT_EMPTY,           ROW_PREDICTED, NO_HIT},
        '{rwsp_pkg::MARK_EQ_HEADER,           ROW_PREDICTED, NO_HIT},  // empty marker closes
        '{rwsp_pkg::MARK_EQ_START,            ROW_PREDICTED, NO_HIT},  // header tracking on
        '{32'h0000_0000,                      ROW_PREDICTED, NO_HIT},
        '{32'h0000_0003,                      ROW_PREDICTED, NO_HIT}   // bad check word
    };

    logic clk;
    logic rst_n;

    rwsp_word_if word_ch();
    rwsp_hit_if  hit_ch();

    readout_word_stream_hit_parser_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_word  (word_ch),
        .o_hit   (hit_ch)
    );

    // Parser tracking state mirrored by the testbench
    logic [31:0] trk_prev   = '0;
    logic [31:0] trk_prev2  = '0;
    logic        trk_in_evt = 1'b0;
    logic        trk_in_eq  = 1'b0;
    logic [4:0]  trk_hdr    = '0;
    logic [1:0]  trk_pos    = '0;
    logic        trk_par    = 1'b0;
    logic [7:0]  trk_fe     = '0;
    logic [7:0]  trk_chip   = '0;
    logic [31:0] trk_trig   = '0;
    logic [31:0] trk_wraps  = '0;

    rwsp_pkg::t_hit pending_hits[$];
    int   fault_count = 0;
    int   words_sent  = 0;
    bit   tx_steady   = 1'b0;
    bit   hold_req    = 1'b0;
    logic hold_hits;

    // One word against its history; true when a word pair completes
    function automatic bit track_word(input logic [31:0] w, input logic [31:0] p,
                                      input logic [31:0] pp);
        bit pair_done;
        pair_done = 1'b0;

        // markers in the previous word
        if (p[31:8] == rwsp_pkg::MARK_EVT_HEADER) begin
            trk_in_evt = 1'b1;
            trk_in_eq  = 1'b0;
            trk_hdr    = '0;
            trk_pos    = '0;
            trk_par    = 1'b0;
        end else if (p == rwsp_pkg::MARK_EVT_EMPTY) begin
            trk_in_evt = 1'b0;
        end else if (p == rwsp_pkg::MARK_EQ_HEADER && w == rwsp_pkg::MARK_EQ_START) begin
            trk_in_evt = 1'b0;
            if (pp != rwsp_pkg::MARK_EQ_START) begin
                trk_in_eq = 1'b1;
            end
        end

        // equipment header words
        if (trk_in_eq) begin
            if (trk_hdr != rwsp_pkg::HDR_CNT_MAX) begin
                trk_hdr = trk_hdr + 5'd1;
            end
            if (trk_hdr == rwsp_pkg::HDR_CHECK_POS && w != rwsp_pkg::HDR_CHECK_VALUE) begin
                trk_in_eq = 1'b0;
            end
            if (trk_hdr == rwsp_pkg::HDR_FE_POS) begin
                trk_fe = p[7:0];
            end
        end

        // event body
        if (trk_in_evt) begin
            if (trk_pos != rwsp_pkg::EVT_POS_DATA) begin
                trk_pos = trk_pos + 2'd1;
            end
            trk_par = ~trk_par;
            if (trk_pos == rwsp_pkg::EVT_POS_CHIP) begin
                trk_chip = p[7:0];
            end else if (w[31:8] != rwsp_pkg::MARK_EVT_HEADER && w != rwsp_pkg::MARK_END) begin
                if (trk_pos == rwsp_pkg::EVT_POS_TRIG) begin
                    if (trk_trig > p) begin
                        trk_wraps = trk_wraps + 32'd1;
                    end
                    trk_trig = p;
                end
                pair_done = (trk_pos == rwsp_pkg::EVT_POS_DATA) && !trk_par;
            end
        end
        return pair_done;
    endfunction

    // Bit-reverse both words and pick the hit fields
    function automatic rwsp_pkg::t_hit decode_pair(input logic [31:0] hit_w,
                                                   input logic [31:0] time_w);
        logic [31:0] s;
        logic [31:0] t;
        logic [11:0] gray;
        logic [11:0] bin;
        rwsp_pkg::t_hit h;
        for (int i = 0; i < 32; i++) begin
            s[i] = hit_w[31-i];
            t[i] = time_w[31-i];
        end
        gray    = {t[5:0], t[15:10]};
        bin[11] = gray[11];
        for (int i = 10; i >= 0; i--) begin
            bin[i] = bin[i+1] ^ gray[i];
        end
        h.frontend_id    = trk_fe;
        h.chip_id        = trk_chip;
        h.channel        = s[7:2];
        h.hit_flag       = s[0];
        h.above_thr      = s[1];
        h.amplitude      = {t[17:16], t[31:24]};
        h.bunch_id       = bin;
        h.fine_time      = {t[9:8], t[23:18]};
        h.trigger_time   = trk_trig;
        h.trigger_wraps  = trk_wraps;
        return h;
    endfunction

    // Advance the tracker by one accepted word; returns the hit it causes, if any
    function automatic bit predict_hit(input logic [31:0] w, output rwsp_pkg::t_hit h);
        logic [31:0] p;
        logic [31:0] pp;
        bit          pair_done;
        p  = trk_prev;
        pp = trk_prev2;
        if (p == rwsp_pkg::MARK_END) begin
            // event closed, then a zero word and the current word on zero history
            trk_in_evt = 1'b0;
            void'(track_word('0, '0, '0));
            pair_done = track_word(w, '0, '0);
            trk_prev2 = '0;
        end else begin
            pair_done = track_word(w, p, pp);
            trk_prev2 = p;
        end
        trk_prev = w;
        h = decode_pair(p, pp);
        return pair_done;
    endfunction

    // Marker-heavy word for noise and broken sequences
    function automatic logic [31:0] stray_word();
        case ($urandom_range(0, 7))
            0: return rwsp_pkg::MARK_END;
            1: return rwsp_pkg::MARK_EVT_EMPTY;
            2: return rwsp_pkg::MARK_EQ_HEADER;
            3: return rwsp_pkg::MARK_EQ_START;
            4: return {rwsp_pkg::MARK_EVT_HEADER, 8'($urandom)};
            5: return rwsp_pkg::HDR_CHECK_VALUE;
            default: return $urandom;
        endcase
    endfunction

    function automatic void cmp_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
        if (want !== got) begin
            $error("hit field %s: expected 0x%0h, got 0x%0h", name, want, got);
            fault_count++;
        end
    endfunction

    function automatic void check_hit(input rwsp_pkg::t_hit want);
        cmp_field("frontend_id",    32'(want.frontend_id),    32'(hit_ch.frontend_id));
        cmp_field("chip_id",        32'(want.chip_id),        32'(hit_ch.chip_id));
        cmp_field("channel",        32'(want.channel),        32'(hit_ch.channel));
        cmp_field("hit_flag",       32'(want.hit_flag),       32'(hit_ch.hit_flag));
        cmp_field("above_thr",      32'(want.above_thr),      32'(hit_ch.above_thr));
        cmp_field("amplitude",      32'(want.amplitude),      32'(hit_ch.amplitude));
        cmp_field("bunch_id",       32'(want.bunch_id),       32'(hit_ch.bunch_id));
        cmp_field("fine_time",      32'(want.fine_time),      32'(hit_ch.fine_time));
        cmp_field("trigger_time",   want.trigger_time,        hit_ch.trigger_time);
        cmp_field("trigger_wraps",  want.trigger_wraps,       hit_ch.trigger_wraps);
    endfunction

    // Offer one word after a random gap, none in steady mode; predict once the request is taken
    task automatic send_word(input logic [31:0] w, input bit typed = 1'b0,
                             input rwsp_pkg::t_hit typed_hit = '0);
        int   gap;
        rwsp_pkg::t_hit h;
        gap = tx_steady ? 0 : $urandom_range(0, 19);
        @(negedge clk);
        if (gap > 0) begin
            word_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        word_ch.valid <= 1'b1;
        word_ch.word  <= w;
        do @(posedge clk); while (!word_ch.ready);
        if (predict_hit(w, h)) begin
            pending_hits.insert(pending_hits.size(), typed ? typed_hit : h);
        end
        words_sent++;
    endtask

    // Stop offering words, then wait until every predicted hit has come
    task automatic drain_hits();
        @(negedge clk);
        word_ch.valid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge clk);
    endtask

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("readout_word_stream_hit_parser_top verification failed");
        $finish;
    end

    // Long hold-off on the hit side, counted here
    initial begin
        hold_hits = 1'b0;
        wait (hold_req);
        @(posedge clk);
        hold_hits <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_hits <= 1'b0;
    end

    // Hit side: random stall before each request, steady stretches now and then
    initial begin
        int stall;
        bit rx_steady;
        rx_steady    = 1'b0;
        hit_ch.ready = 1'b0;
        wait (rst_n);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, 19);
            if (stall != 0 || hold_hits) begin
                hit_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
                while (hold_hits) @(negedge clk);
            end
            hit_ch.ready <= 1'b1;
            do @(posedge clk); while (!hit_ch.valid);
            @(negedge clk);
            if ($urandom_range(0, 29) == 0) begin
                rx_steady = ~rx_steady;
            end
        end
    end

    // Check every hit taken against the oldest prediction
    always @(posedge clk) begin
        if (rst_n && hit_ch.valid && hit_ch.ready) begin
            if (pending_hits.size() == 0) begin
                $error("hit with no prediction pending: channel 0x%0h", hit_ch.channel);
                fault_count++;
            end else begin
                check_hit(pending_hits.pop_front());
            end
        end
    end

    // Stimulus
    initial begin
        int n;
        int sel;
        bit pressure_done;
        pressure_done = 1'b0;
        rst_n         = 1'b0;
        word_ch.valid = 1'b0;
        word_ch.word  = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < DIR_ROWS; i++) begin
            send_word(DIR_TABLE[i].word, DIR_TABLE[i].kind == ROW_TYPED, DIR_TABLE[i].hit);
        end
        drain_hits();

        // random streams, mostly well-formed
        while (words_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 7) == 0) begin
                tx_steady = ~tx_steady;
            end
            if (!pressure_done && words_sent >= PRESSURE_AT) begin
                // long event at full rate while the hit side is held off
                tx_steady = 1'b1;
                hold_req  = 1'b1;
                send_word({rwsp_pkg::MARK_EVT_HEADER, 8'($urandom)});
                repeat (PRESSURE_WORDS) send_word($urandom);
                drain_hits();
                pressure_done = 1'b1;
            end
            sel = $urandom_range(0, 9);
            if (sel < 2) begin
                // equipment header, usually with a good check word
                send_word(rwsp_pkg::MARK_EQ_HEADER);
                send_word(rwsp_pkg::MARK_EQ_START);
                send_word($urandom);
                send_word(($urandom_range(0, 4) != 0) ? rwsp_pkg::HDR_CHECK_VALUE : $urandom);
                n = $urandom_range(0, 30);
                repeat (n) send_word(($urandom_range(0, 19) == 0) ? stray_word() : $urandom);
            end else if (sel < 8) begin
                // event: header, trigger time, word pairs, optional closing marker
                send_word({rwsp_pkg::MARK_EVT_HEADER, 8'($urandom)});
                send_word(($urandom_range(0, 2) == 0) ? $urandom_range(0, 255) : $urandom);
                n = $urandom_range(0, 24);
                repeat (n) send_word(($urandom_range(0, 24) == 0) ? stray_word() : $urandom);
                case ($urandom_range(0, 3))
                    0: send_word(rwsp_pkg::MARK_END);
                    1: send_word(rwsp_pkg::MARK_EVT_EMPTY);
                    default: ;
                endcase
            end else begin
                n = $urandom_range(1, 6);
                repeat (n) send_word(stray_word());
            end
        end
        @(negedge clk);
        word_ch.valid <= 1'b0;

        drain_hits();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fault_count == 0) begin
            $display("readout_word_stream_hit_parser_top verification clean");
        end else begin
            $display("readout_word_stream_hit_parser_top verification failed");
        end
        $finish;
    end

endmodule
